// ===== rtl/bb3_pkg.sv =====
// Package for the 3x3 edge-clipped box blur: shared constants and the
// command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package bb3_pkg;

  localparam int CH_BITS    = 8;
  localparam int PIX_BITS   = 24;
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 13;
  localparam int CFG_D_BITS = 13;
  localparam int ROW_BITS   = 13;
  localparam int OROW_BITS  = 12;
  localparam int CSUM_BITS  = 10;
  localparam int TSUM_BITS  = 12;
  localparam int NUM_BITS   = 13;
  localparam int CNT_BITS   = 4;
  localparam int DEN_BITS   = 5;
  localparam int QSTEP_BITS = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RST = 13'd480;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic take;
    logic upd;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic emit;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/bb3_div.sv =====
// Three-lane restoring divider that forms one quotient bit per cycle while step is asserted.
// Uses bb3_pkg; instantiated by the datapath bb3_dp.
`default_nettype none

module bb3_div (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         start,
  input  wire logic                                         step,
  input  wire logic [2:0][bb3_pkg::NUM_BITS-1:0]            numer,
  input  wire logic [bb3_pkg::DEN_BITS-1:0]                 den,
  output logic                                              done,
  output logic [2:0][bb3_pkg::CH_BITS-1:0]                  quo
);
  import bb3_pkg::*;

  logic [2:0][NUM_BITS-1:0]  rem_r;
  logic [2:0][CH_BITS-1:0]   quo_r;
  logic [DEN_BITS-1:0]       den_r;
  logic [QSTEP_BITS-1:0]     step_r;
  logic [NUM_BITS-1:0]       den_sh;

  // The quotient is known to fit in eight bits, so the divisor starts
  // shifted up by seven and walks down one place per step.
  assign den_sh = NUM_BITS'(den_r) << step_r;
  assign done   = (step_r == '0);
  assign quo    = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= QSTEP_BITS'(CH_BITS - 1);
    end else if (step) begin
      step_r <= step_r - QSTEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer;
      quo_r <= '0;
      den_r <= den;
    end else if (step) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_r[ch] >= den_sh) begin
          rem_r[ch]         <= rem_r[ch] - den_sh;
          quo_r[ch][step_r] <= 1'b1;
        end
      end
    end
  end

  a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (numer[0] < (NUM_BITS'(den) << CH_BITS)) &&
              (numer[1] < (NUM_BITS'(den) << CH_BITS)) &&
              (numer[2] < (NUM_BITS'(den) << CH_BITS)))
    else $error("dividend too large for an eight-bit quotient");

endmodule

`default_nettype wire

// ===== rtl/bb3_ctrl.sv =====
// Controller state machine for the box blur: sequences memory read,
// window update, sums, division and result load. Uses bb3_pkg.
`default_nettype none

module bb3_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire bb3_pkg::stat_t stat,
  output bb3_pkg::cmd_t       cmd
);
  import bb3_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        // A drain transaction that arrives before the frame is complete
        // is consumed here and has no further effect.
        if (in_tvalid && !stat.skip) begin
          cmd.take  = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.upd   = 1'b1;
        state_nxt = stat.emit ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        cmd.start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && stat.div_done) |=> (state_r == ST_OUT))
    else $error("division finished but no result load followed");

endmodule

`default_nettype wire

// ===== rtl/bb3_dp.sv =====
// Datapath for the box blur: configuration registers, position counters,
// two line memories, the 3x2 window, sums, divider and output register.
// Uses bb3_pkg and bb3_div.
`default_nettype none

module bb3_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [bb3_pkg::CFG_D_BITS-1:0]    cfg_wdata,
  input  wire logic [bb3_pkg::PIX_BITS-1:0]      in_tdata,
  input  wire logic                              in_tuser,
  input  wire logic                              out_tready,
  output logic                                   out_tvalid,
  output logic [bb3_pkg::PIX_BITS-1:0]           out_tdata,
  output logic                                   out_tlast,
  input  wire bb3_pkg::cmd_t                     cmd,
  output bb3_pkg::stat_t                         stat
);
  import bb3_pkg::*;

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW   = (CW > CFG_W_BITS) ? CW + 1 : CFG_W_BITS + 1;
  localparam int WCAP = (MAX_WIDTH < (1 << CFG_W_BITS) - 1) ? MAX_WIDTH
                                                            : (1 << CFG_W_BITS) - 1;

  logic [CFG_W_BITS-1:0] width_r;
  logic [CFG_H_BITS-1:0] height_r;
  logic [CFG_W_BITS-1:0] w_eff;
  logic [CFG_H_BITS-1:0] h_eff;

  logic [CW-1:0]         in_col_r, in_col_nxt;
  logic [ROW_BITS-1:0]   in_row_r, in_row_nxt;
  logic [CW-1:0]         out_col_r, out_col_nxt;
  logic [OROW_BITS-1:0]  out_row_r, out_row_nxt;

  logic [PIX_BITS-1:0]   upper_mem [MAX_WIDTH];
  logic [PIX_BITS-1:0]   middle_mem [MAX_WIDTH];
  logic [PIX_BITS-1:0]   up_rd_r;
  logic [PIX_BITS-1:0]   mid_rd_r;
  logic [PIX_BITS-1:0]   pix_r;
  logic                  drain_r;

  logic [PIX_BITS-1:0]   left_r [3];
  logic [PIX_BITS-1:0]   mid_r [3];
  logic [PIX_BITS-1:0]   colw [3][3];

  logic                  draining;
  logic                  emit;
  logic                  in_col_wrap;
  logic                  out_col_wrap;
  logic                  use_left;
  logic                  use_right;
  logic                  use_top;
  logic                  use_bot;
  logic                  last_now;
  logic                  last_r;

  logic [CSUM_BITS-1:0]  colsum_nxt [3][3];
  logic [CSUM_BITS-1:0]  colsum_r [3][3];
  logic [1:0]            rows_in;
  logic [1:0]            cols_in;
  logic [CNT_BITS-1:0]   n_r;

  logic [2:0][NUM_BITS-1:0] numer;
  logic [2:0][CH_BITS-1:0]  quo;
  logic                     div_done;

  logic                  out_tvalid_r;
  logic [PIX_BITS-1:0]   out_tdata_r;
  logic                  out_tlast_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[CFG_W_BITS-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[CFG_H_BITS-1:0];
      endcase
    end
  end

  assign w_eff = (width_r == '0) ? CFG_W_BITS'(1) :
                 (width_r > CFG_W_BITS'(WCAP)) ? CFG_W_BITS'(WCAP) : width_r;
  assign h_eff = (height_r == '0) ? CFG_H_BITS'(1) :
                 (height_r > CFG_H_BITS'(MAX_HEIGHT)) ? CFG_H_BITS'(MAX_HEIGHT) : height_r;

  // Position decode.
  assign draining     = (in_row_r >= h_eff);
  assign emit         = (in_row_r >= ROW_BITS'(2)) ||
                        ((in_row_r == ROW_BITS'(1)) && (in_col_r != '0));
  assign in_col_wrap  = (XW'(in_col_r) + XW'(1)) >= XW'(w_eff);
  assign out_col_wrap = (XW'(out_col_r) + XW'(1)) >= XW'(w_eff);
  assign use_left     = (out_col_r != '0);
  assign use_right    = !out_col_wrap;
  assign use_top      = (out_row_r != '0);
  assign use_bot      = (ROW_BITS'(out_row_r) + ROW_BITS'(1)) < h_eff;
  assign last_now     = out_col_wrap && !use_bot;

  // Line memories: read when a transaction is taken, written back when the
  // window moves on a non-drain transaction; the address stays put in between.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      up_rd_r  <= upper_mem[in_col_r];
      mid_rd_r <= middle_mem[in_col_r];
      pix_r    <= draining ? '0 : in_tdata;
      drain_r  <= draining;
    end
    if (cmd.upd && !drain_r) begin
      upper_mem[in_col_r]  <= mid_rd_r;
      middle_mem[in_col_r] <= pix_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      colw[0][k] = left_r[k];
      colw[1][k] = mid_r[k];
    end
    colw[2][0] = up_rd_r;
    colw[2][1] = mid_rd_r;
    colw[2][2] = pix_r;
  end

  // Column sums per channel with neighbors outside the frame masked off.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int ch = 0; ch < 3; ch++) begin
        colsum_nxt[i][ch] =
          (use_top ? CSUM_BITS'(colw[i][0][CH_BITS*ch +: CH_BITS]) : '0) +
          CSUM_BITS'(colw[i][1][CH_BITS*ch +: CH_BITS]) +
          (use_bot ? CSUM_BITS'(colw[i][2][CH_BITS*ch +: CH_BITS]) : '0);
      end
    end
    if (!use_left) begin
      for (int ch = 0; ch < 3; ch++) begin
        colsum_nxt[0][ch] = '0;
      end
    end
    if (!use_right) begin
      for (int ch = 0; ch < 3; ch++) begin
        colsum_nxt[2][ch] = '0;
      end
    end
  end

  assign rows_in = 2'd1 + 2'(use_top) + 2'(use_bot);
  assign cols_in = 2'd1 + 2'(use_left) + 2'(use_right);

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      colsum_r <= colsum_nxt;
      n_r      <= CNT_BITS'(rows_in) * CNT_BITS'(cols_in);
      last_r   <= last_now;
    end
  end

  // Window shift and position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        left_r[k] <= '0;
        mid_r[k]  <= '0;
      end
    end else if (cmd.upd) begin
      for (int k = 0; k < 3; k++) begin
        left_r[k] <= mid_r[k];
        mid_r[k]  <= colw[2][k];
      end
    end
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (cmd.upd) begin
      if (emit && last_now) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (emit) begin
          if (out_col_wrap) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + OROW_BITS'(1);
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end
        if (in_col_wrap) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + ROW_BITS'(1);
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Rounded mean: (2*sum + n) / (2*n).
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      numer[ch] = {TSUM_BITS'(colsum_r[0][ch]) + TSUM_BITS'(colsum_r[1][ch]) +
                   TSUM_BITS'(colsum_r[2][ch]), 1'b0} + NUM_BITS'(n_r);
    end
  end

  bb3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .step  (cmd.step),
    .numer (numer),
    .den   ({n_r, 1'b0}),
    .done  (div_done),
    .quo   (quo)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata_r <= {quo[2], quo[1], quo[0]};
      out_tlast_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign stat.skip     = in_tuser && !draining;
  assign stat.emit     = emit;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_tvalid_r || out_tready;

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(in_col_r) < XW'(w_eff))
    else $error("input column beyond row width");

  a_out_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    ROW_BITS'(out_row_r) < h_eff)
    else $error("output row beyond frame height");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && emit && last_now && !cfg_we) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("counters not cleared after the last pixel of a frame");

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_edge_clipped.sv =====
// 3x3 box blur over an RGB raster stream; neighbors outside the frame are
// left out of the mean. Top level: joins bb3_ctrl and bb3_dp, uses bb3_pkg.
//
// Usage:
//  - Input channel in_*: one pixel per transaction in raster order. in_tuser
//    is the mode: 0 carries a pixel, 1 is a drain transaction. Results lag by
//    one row plus one pixel, so each frame takes width*height pixels and then
//    width+1 drain transactions to flush its tail. Early drains are dropped.
//  - Output channel out_*: one blurred pixel per transaction, out_tlast high
//    on the final pixel of the frame.
//  - Configuration port cfg_*: index 0 is the width (1..MAX_WIDTH, at most 2047),
//    index 1 the height (1..4096); a write restarts the frame. Write only when idle.
//  - Flow: one transaction is taken per visit to the idle state. A transaction
//    that yields a result passes through line memory read, window update, sum,
//    eight steps of the bit-serial divider and the output load, which waits
//    while the output register is full; one that yields no result ends after
//    the window update, and a dropped drain stays in the idle state.
//  - Reset returns to 640x480 and clears counters and window; the line
//    memories are not cleared and need no clearing pass.
//  - A stalled receiver holds the result in the output register; the next
//    transaction is still accepted and processed up to its own result load.
`default_nettype none

module box_blur_3x3_edge_clipped #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [bb3_pkg::CFG_D_BITS-1:0] cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [bb3_pkg::PIX_BITS-1:0]   in_tdata,   // red_in, green_in, blue_in
  input  wire logic                           in_tuser,   // mode
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [bb3_pkg::PIX_BITS-1:0]        out_tdata,  // red_out, green_out, blue_out
  output logic                                out_tlast
);
  import bb3_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bb3_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire
